// ===== design/ftacc_pkg.sv =====
// shared types and constants of the frame time accumulator
package ftacc_pkg;

  localparam int FRAME_MS = 20;
  localparam int CLIP_MS = 300;
  localparam int DIV_W = 96;
  localparam int DVS_W = 36;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int NUM_W = 88;

  localparam logic [25:0] STEP_ONE = 26'd16777216;
  localparam logic [31:0] STEP_MAX = 32'd50331648;
  localparam logic [31:0] STEP_MIN = 32'd168;
  localparam logic [31:0] STEP_FLOOR = 32'd167772;
  localparam logic [17:0] FPS_MAX = 18'd256000;
  localparam logic [23:0] SCALE_ONE = 24'd65536;

  typedef enum logic [2:0] {
    REQ_START  = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_SUSP   = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_STOP   = 3'd4
  } req_code_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] counter_now;
    logic        user_pause;
    logic        code_pause;
    logic        snapshot_active;
  } in_req_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [31:0] prev_time_ms;
    logic [31:0] prev2_time_ms;
    logic [31:0] prev3_time_ms;
    logic [31:0] prev4_time_ms;
    logic [31:0] unclipped_ms;
    logic [31:0] pause_mode_ms;
    logic [25:0] time_step;
    logic [25:0] old_time_step;
    logic [31:0] raw_time_step;
    logic [17:0] fps_q8;
    logic [31:0] frame_count;
  } out_res_t;

endpackage

// ===== design/ftacc_div.sv =====
// shared bit-serial restoring divider, one quotient bit per cycle
module ftacc_div import ftacc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign trial = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    q_nxt = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      dvs_nxt = divisor;
      q_nxt = dividend;
    end else if (busy_r) begin
      if (!trial[DVS_W]) begin
        rem_nxt = trial[DVS_W-1:0];
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r <= q_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule

// ===== design/ftacc_regs.sv =====
// configuration registers behind the apb port
module ftacc_regs import ftacc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [19:0] cycles_per_ms,
  output logic [23:0] time_scale
);

  logic [19:0] cpm_r, cpm_nxt;
  logic [23:0] scale_r, scale_nxt;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_comb begin
    cpm_nxt = cpm_r;
    scale_nxt = scale_r;
    if (wr) begin
      if (paddr[2]) scale_nxt = pwdata[23:0];
      else cpm_nxt = pwdata[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r <= 20'd1;
      scale_r <= SCALE_ONE;
    end else begin
      cpm_r <= cpm_nxt;
      scale_r <= scale_nxt;
    end
  end

  assign prdata = paddr[2] ? {8'd0, scale_r} : {12'd0, cpm_r};
  assign cycles_per_ms = cpm_r;
  assign time_scale = scale_r;

endmodule

// ===== design/frame_time_accumulator.sv =====
// frame time accumulator top level: sequencer, clock state and result register
//
// each request on the in_ channel carries a request code and a 64-bit raw
// counter value; every accepted request gives exactly one result on the out_
// channel showing all clocks, history, time steps, fps and frame count after it.
// start, suspend, resume and stop take effect at once and their result
// passes through the pending flag into the output register once that is free.
// a frame tick runs two 32x24 partial products and an add, then uses one
// shared 96-step bit-serial divider up to three times (milliseconds, raw time
// step, fps); the raw time step division is skipped when paused.
// in_stall is high while a request is worked on or its result is pending;
// one finished result may wait in the output register while the next request
// is accepted. when out_stall and out_valid are high the result register holds
// and the sequencer waits before writing the following result.
// reset (synchronous, active low) puts the clocks and steps to their start
// values, cycles_per_ms to 1 and time_scale to 1.0.
// configuration is written through the apb port: cycles_per_ms at 0,
// time_scale at 4; pready is always high.
module frame_time_accumulator import ftacc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MUL0 = 8'b00000010,
    S_MUL1 = 8'b00000100,
    S_ADD  = 8'b00001000,
    S_DMS  = 8'b00010000,
    S_DRAW = 8'b00100000,
    S_DFPS = 8'b01000000,
    S_FIN  = 8'b10000000
  } st_t;

  st_t state_r, state_nxt;
  logic out_pend_r, out_pend_nxt;

  logic [19:0] cpm;
  logic [23:0] tscale;
  logic [19:0] cpm_eff;

  logic [31:0] clipped_r, clipped_nxt;
  logic [31:0] unclipped_r, unclipped_nxt;
  logic [31:0] pclk_r, pclk_nxt;
  logic [31:0] hist_r [4];
  logic [31:0] hist_nxt [4];
  logic [31:0] prev_unc_r, prev_unc_nxt;
  logic [63:0] ref_r, ref_nxt;
  logic [63:0] cap_r, cap_nxt;
  logic [7:0]  nest_r, nest_nxt;
  logic        run_r, run_nxt;
  logic [25:0] step_r, step_nxt;
  logic [25:0] step_old_r, step_old_nxt;
  logic [31:0] raw_r, raw_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [17:0] fps_r, fps_nxt;

  logic [63:0] delta_r, delta_nxt;
  logic [31:0] diff_r, diff_nxt;
  logic        paused_r, paused_nxt;
  logic        snap_r, snap_nxt;
  logic [55:0] plo_r, plo_nxt;
  logic [55:0] phi_r, phi_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic        dstart_r, dstart_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_res_t         out_data_r, out_data_nxt;

  logic [31:0]      mul_a;
  logic [23:0]      mul_b;
  logic [55:0]      prod;
  logic [DIV_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [31:0]      raw_sat;
  logic [31:0]      raw_fl;
  logic [31:0]      ms_clip;
  logic [7:0]       nest_inc;
  logic             accept;
  logic             out_free;

  ftacc_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .cycles_per_ms (cpm),
    .time_scale    (tscale)
  );

  ftacc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dstart_r),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pready = 1'b1;
  assign cpm_eff = (cpm == 20'd0) ? 20'd1 : cpm;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || out_pend_r;
  assign out_free = !out_valid_r || !out_stall;

  assign mul_a = (state_r == S_MUL0) ? delta_r[31:0] : delta_r[63:32];
  assign mul_b = paused_r ? SCALE_ONE : tscale;
  assign prod = 56'(mul_a) * 56'(mul_b);

  always_comb begin
    div_dvd = 96'(num_r);
    div_dvs = {cpm_eff, 16'd0};
    unique case (state_r)
      S_DRAW: begin
        div_dvd = {num_r, 8'd0};
        div_dvs = 36'(cpm_eff) * 36'(FRAME_MS);
      end
      S_DFPS: begin
        div_dvd = 96'(FPS_MAX);
        div_dvs = 36'(diff_r);
      end
      default: begin
        div_dvd = 96'(num_r);
        div_dvs = {cpm_eff, 16'd0};
      end
    endcase
  end

  assign ms_clip = (div_q > 96'(CLIP_MS)) ? 32'(CLIP_MS) : div_q[31:0];
  assign raw_sat = (div_q[DIV_W-1:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];
  assign raw_fl = (!snap_r && raw_sat < STEP_FLOOR) ? STEP_FLOOR : raw_sat;
  assign nest_inc = (nest_r != 8'd255) ? nest_r + 8'd1 : nest_r;

  always_comb begin
    state_nxt = state_r;
    out_pend_nxt = out_pend_r;
    clipped_nxt = clipped_r;
    unclipped_nxt = unclipped_r;
    pclk_nxt = pclk_r;
    hist_nxt = hist_r;
    prev_unc_nxt = prev_unc_r;
    ref_nxt = ref_r;
    cap_nxt = cap_r;
    nest_nxt = nest_r;
    run_nxt = run_r;
    step_nxt = step_r;
    step_old_nxt = step_old_r;
    raw_nxt = raw_r;
    frames_nxt = frames_r;
    fps_nxt = fps_r;
    delta_nxt = delta_r;
    diff_nxt = diff_r;
    paused_nxt = paused_r;
    snap_nxt = snap_r;
    plo_nxt = plo_r;
    phi_nxt = phi_r;
    num_nxt = num_r;
    dstart_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_pend_nxt = 1'b1;
          unique case (in_data.req_type)
            REQ_START: begin
              clipped_nxt = '0;
              unclipped_nxt = 32'd1;
              pclk_nxt = 32'd1;
              for (int i = 0; i < 4; i++) hist_nxt[i] = '0;
              prev_unc_nxt = '0;
              ref_nxt = in_data.counter_now;
              nest_nxt = '0;
              run_nxt = 1'b0;
              step_nxt = STEP_ONE;
              step_old_nxt = STEP_ONE;
              frames_nxt = '0;
              fps_nxt = '0;
            end
            REQ_TICK: begin
              out_pend_nxt = 1'b0;
              state_nxt = S_MUL0;
              run_nxt = 1'b1;
              diff_nxt = unclipped_r - prev_unc_r;
              hist_nxt[3] = hist_r[2];
              hist_nxt[2] = hist_r[1];
              hist_nxt[1] = hist_r[0];
              hist_nxt[0] = clipped_r;
              prev_unc_nxt = unclipped_r;
              delta_nxt = in_data.counter_now - ref_r;
              ref_nxt = in_data.counter_now;
              paused_nxt = in_data.user_pause || in_data.code_pause;
              snap_nxt = in_data.snapshot_active;
            end
            REQ_SUSP: begin
              if (run_r) begin
                nest_nxt = nest_inc;
                if (nest_inc <= 8'd1) cap_nxt = in_data.counter_now;
              end
            end
            REQ_RESUME: begin
              if (run_r && nest_r != 8'd0) begin
                nest_nxt = nest_r - 8'd1;
                if (nest_r == 8'd1) ref_nxt = in_data.counter_now - cap_r + ref_r;
              end
            end
            REQ_STOP: begin
              for (int i = 0; i < 4; i++) hist_nxt[i] = clipped_r;
              run_nxt = 1'b0;
              prev_unc_nxt = unclipped_r;
            end
            default: ;
          endcase
        end
      end
      S_MUL0: begin
        plo_nxt = prod;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        phi_nxt = prod;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        num_nxt = NUM_W'(plo_r) + {phi_r, 32'd0};
        state_nxt = S_DMS;
        dstart_nxt = 1'b1;
      end
      S_DMS: begin
        if (div_done) begin
          pclk_nxt = pclk_r + div_q[31:0];
          if (paused_r) begin
            raw_nxt = '0;
            if (diff_r == '0) begin
              fps_nxt = FPS_MAX;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_DFPS;
              dstart_nxt = 1'b1;
            end
          end else begin
            unclipped_nxt = unclipped_r + div_q[31:0];
            clipped_nxt = clipped_r + ms_clip;
            state_nxt = S_DRAW;
            dstart_nxt = 1'b1;
          end
        end
      end
      S_DRAW: begin
        if (div_done) begin
          raw_nxt = raw_fl;
          if (diff_r == '0) begin
            fps_nxt = FPS_MAX;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_DFPS;
            dstart_nxt = 1'b1;
          end
        end
      end
      S_DFPS: begin
        if (div_done) begin
          fps_nxt = div_q[17:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        step_old_nxt = step_r;
        if (raw_r > STEP_MAX) step_nxt = STEP_MAX[25:0];
        else if (raw_r >= STEP_MIN) step_nxt = raw_r[25:0];
        else step_nxt = STEP_MIN[25:0];
        frames_nxt = frames_r + 32'd1;
        out_pend_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_pend_r && out_free) begin
      out_pend_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt.time_ms = clipped_r;
      out_data_nxt.prev_time_ms = hist_r[0];
      out_data_nxt.prev2_time_ms = hist_r[1];
      out_data_nxt.prev3_time_ms = hist_r[2];
      out_data_nxt.prev4_time_ms = hist_r[3];
      out_data_nxt.unclipped_ms = unclipped_r;
      out_data_nxt.pause_mode_ms = pclk_r;
      out_data_nxt.time_step = step_r;
      out_data_nxt.old_time_step = step_old_r;
      out_data_nxt.raw_time_step = raw_r;
      out_data_nxt.fps_q8 = fps_r;
      out_data_nxt.frame_count = frames_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      dstart_r <= 1'b0;
      clipped_r <= '0;
      unclipped_r <= 32'd1;
      pclk_r <= 32'd1;
      for (int i = 0; i < 4; i++) hist_r[i] <= '0;
      prev_unc_r <= '0;
      ref_r <= '0;
      cap_r <= '0;
      nest_r <= '0;
      run_r <= 1'b0;
      step_r <= STEP_ONE;
      step_old_r <= STEP_ONE;
      raw_r <= '0;
      frames_r <= '0;
      fps_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_pend_r <= out_pend_nxt;
      out_valid_r <= out_valid_nxt;
      dstart_r <= dstart_nxt;
      clipped_r <= clipped_nxt;
      unclipped_r <= unclipped_nxt;
      pclk_r <= pclk_nxt;
      hist_r <= hist_nxt;
      prev_unc_r <= prev_unc_nxt;
      ref_r <= ref_nxt;
      cap_r <= cap_nxt;
      nest_r <= nest_nxt;
      run_r <= run_nxt;
      step_r <= step_nxt;
      step_old_r <= step_old_nxt;
      raw_r <= raw_nxt;
      frames_r <= frames_nxt;
      fps_r <= fps_nxt;
    end
    delta_r <= delta_nxt;
    diff_r <= diff_nxt;
    paused_r <= paused_nxt;
    snap_r <= snap_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    num_r <= num_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== dv/frame_time_accumulator_check.sv =====
// checker: watches the request, result and apb channels and predicts every result
module frame_time_accumulator_check import ftacc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_req_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_res_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          pending,
  output int          fail_count
);

  localparam logic [2:0] ADDR_CPM = 3'd0;
  localparam logic [2:0] ADDR_SCALE = 3'd4;

  logic [19:0] cpm_reg;
  logic [23:0] scale_reg;

  logic [31:0] clip_clk, free_clk, pause_clk, prev_free;
  logic [31:0] hist [4];
  logic [63:0] ref_cnt, susp_cnt;
  logic [7:0]  nest;
  logic        running;
  logic [25:0] step_cur, step_old;
  logic [31:0] step_raw, frames;
  logic [17:0] fps;

  out_res_t expected_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic compare(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task automatic clear_state(logic [63:0] now);
    clip_clk = 0;
    free_clk = 1;
    pause_clk = 1;
    for (int i = 0; i < 4; i++) hist[i] = 0;
    prev_free = 0;
    ref_cnt = now;
    nest = 0;
    running = 0;
    step_cur = STEP_ONE;
    step_old = STEP_ONE;
    frames = 0;
    fps = 0;
  endtask

  task automatic frame_tick(logic [63:0] now, logic paused, logic snap);
    logic [127:0] cpm, num, ms, rq;
    logic [63:0]  scl, delta;
    logic [31:0]  diff, raw;
    cpm = (cpm_reg == 0) ? 128'd1 : 128'(cpm_reg);
    scl = paused ? 64'd65536 : 64'(scale_reg);
    running = 1;
    diff = free_clk - prev_free;
    fps = (diff != 0) ? 18'(32'(FPS_MAX) / diff) : FPS_MAX;
    hist[3] = hist[2];
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = clip_clk;
    prev_free = free_clk;
    delta = now - ref_cnt;
    ref_cnt = now;
    num = 128'(delta) * 128'(scl);
    ms = num / (cpm << 16);
    pause_clk += ms[31:0];
    if (paused) begin
      raw = 0;
    end else begin
      free_clk += ms[31:0];
      clip_clk += (ms > 128'(CLIP_MS)) ? 32'(CLIP_MS) : ms[31:0];
      rq = (num << 8) / (cpm * 128'(FRAME_MS));
      raw = (rq > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : rq[31:0];
      if (!snap && raw < STEP_FLOOR) raw = STEP_FLOOR;
    end
    step_raw = raw;
    step_old = step_cur;
    if (raw > STEP_MAX) step_cur = STEP_MAX[25:0];
    else if (raw >= STEP_MIN) step_cur = raw[25:0];
    else step_cur = STEP_MIN[25:0];
    frames++;
  endtask

  function automatic out_res_t snapshot_state();
    out_res_t r;
    r.time_ms = clip_clk;
    r.prev_time_ms = hist[0];
    r.prev2_time_ms = hist[1];
    r.prev3_time_ms = hist[2];
    r.prev4_time_ms = hist[3];
    r.unclipped_ms = free_clk;
    r.pause_mode_ms = pause_clk;
    r.time_step = step_cur;
    r.old_time_step = step_old;
    r.raw_time_step = step_raw;
    r.fps_q8 = fps;
    r.frame_count = frames;
    return r;
  endfunction

  always @(posedge clk) begin
    out_res_t w;
    if (!rst_n) begin
      cpm_reg = 1;
      scale_reg = SCALE_ONE;
      clear_state(64'd0);
      susp_cnt = 0;
      step_raw = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_CPM) cpm_reg = pwdata[19:0];
        else if (paddr == ADDR_SCALE) scale_reg = pwdata[23:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_data.time_ms, 0);
        end else begin
          w = expected_q.pop_front();
          compare("time_ms", out_data.time_ms, w.time_ms);
          compare("prev_time_ms", out_data.prev_time_ms, w.prev_time_ms);
          compare("prev2_time_ms", out_data.prev2_time_ms, w.prev2_time_ms);
          compare("prev3_time_ms", out_data.prev3_time_ms, w.prev3_time_ms);
          compare("prev4_time_ms", out_data.prev4_time_ms, w.prev4_time_ms);
          compare("unclipped_ms", out_data.unclipped_ms, w.unclipped_ms);
          compare("pause_mode_ms", out_data.pause_mode_ms, w.pause_mode_ms);
          compare("time_step", 32'(out_data.time_step), 32'(w.time_step));
          compare("old_time_step", 32'(out_data.old_time_step), 32'(w.old_time_step));
          compare("raw_time_step", out_data.raw_time_step, w.raw_time_step);
          compare("fps_q8", 32'(out_data.fps_q8), 32'(w.fps_q8));
          compare("frame_count", out_data.frame_count, w.frame_count);
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.req_type)
          REQ_START: clear_state(in_data.counter_now);
          REQ_TICK: frame_tick(in_data.counter_now, in_data.user_pause | in_data.code_pause,
                               in_data.snapshot_active);
          REQ_SUSP: if (running) begin
            if (nest < 8'd255) nest++;
            if (nest <= 8'd1) susp_cnt = in_data.counter_now;
          end
          REQ_RESUME: if (running && nest != 0) begin
            nest--;
            if (nest == 0) ref_cnt = in_data.counter_now - susp_cnt + ref_cnt;
          end
          REQ_STOP: begin
            for (int i = 0; i < 4; i++) hist[i] = clip_clk;
            running = 0;
            prev_free = free_clk;
          end
          default: ;
        endcase
        expected_q.push_back(snapshot_state());
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/frame_time_accumulator_test.sv =====
// testbench top: clock, reset, request and register stimulus, verdict
module frame_time_accumulator_test;
  import ftacc_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 400;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_res_t    out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          pending, fail_count;

  int          cycles = 0;
  bit          idle_on = 0;
  bit          hold_off = 0;
  bit          hold_done = 0;
  logic [63:0] counter = 0;
  logic [19:0] cpm_cur = 1;
  int          n_req = 0, n_tick = 0, n_phase = 0;

  always #5 clk = ~clk;

  frame_time_accumulator dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  frame_time_accumulator_check checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .pending, .fail_count
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("frame_time_accumulator verification failed");
      $finish;
    end
  end

  // result side stalls, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off && !hold_done) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        out_stall <= 0;
        hold_done = 1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 15);
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send(in_req_t r);
    in_valid <= 1;
    in_data <= r;
    n_req++;
    if (r.req_type == REQ_TICK) n_tick++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_req_t mk(logic [2:0] code, logic [63:0] now,
                                 logic up, logic cp, logic sn);
    in_req_t r;
    r.req_type = code;
    r.counter_now = now;
    r.user_pause = up;
    r.code_pause = cp;
    r.snapshot_active = sn;
    return r;
  endfunction

  task automatic advance();
    logic [63:0] d;
    case ($urandom_range(0, 9))
      0: d = 0;
      1: d = {$urandom, $urandom};
      2: d = 64'($urandom_range(0, 3)) * cpm_cur;
      default: d = 64'($urandom_range(0, 400)) * cpm_cur + 64'($urandom_range(0, cpm_cur));
    endcase
    counter = counter + d;
  endtask

  task automatic random_phase(int count);
    int k;
    logic [2:0] code;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 66) code = REQ_TICK;
      else if (k < 76) code = REQ_SUSP;
      else if (k < 86) code = REQ_RESUME;
      else if (k < 92) code = REQ_STOP;
      else if (k < 96) code = REQ_START;
      else code = 3'($urandom_range(5, 7));
      advance();
      send(mk(code, counter, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
              $urandom_range(0, 4) == 0));
    end
  endtask

  task automatic set_config(logic [19:0] cpm, logic [23:0] scl);
    reg_write(3'd0, 32'(cpm));
    reg_write(3'd4, 32'(scl));
    cpm_cur = (cpm == 0) ? 20'd1 : cpm;
    n_phase++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: tick before start, clamps, pauses, nesting, stop, unknown codes
    send(mk(REQ_TICK, 64'd5, 0, 0, 0));
    send(mk(REQ_RESUME, 64'd6, 0, 0, 0));
    send(mk(REQ_START, 64'd100, 0, 0, 0));
    send(mk(REQ_TICK, 64'd100, 0, 0, 0));
    send(mk(REQ_TICK, 64'd100, 0, 0, 1));
    send(mk(REQ_TICK, 64'd120, 0, 0, 0));
    send(mk(REQ_TICK, 64'd1120, 0, 0, 0));
    send(mk(REQ_TICK, 64'd1180, 1, 0, 0));
    send(mk(REQ_TICK, 64'd1240, 0, 1, 1));
    send(mk(REQ_SUSP, 64'd1300, 0, 0, 0));
    send(mk(REQ_SUSP, 64'd1400, 0, 0, 0));
    send(mk(REQ_RESUME, 64'd1500, 0, 0, 0));
    send(mk(REQ_RESUME, 64'd1600, 0, 0, 0));
    send(mk(REQ_RESUME, 64'd1700, 0, 0, 0));
    send(mk(REQ_TICK, 64'd1750, 0, 0, 0));
    send(mk(REQ_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
    send(mk(REQ_TICK, 64'd3, 1, 1, 1));
    send(mk(REQ_STOP, 64'd10, 0, 0, 0));
    send(mk(REQ_SUSP, 64'd20, 0, 0, 0));
    send(mk(3'd5, 64'd30, 1, 1, 1));
    send(mk(3'd6, 64'd40, 0, 0, 0));
    send(mk(3'd7, 64'hAAAA_5555_AAAA_5555, 1, 0, 1));
    send(mk(REQ_TICK, 64'd2000, 0, 0, 0));
    send(mk(REQ_START, 64'd0, 0, 0, 0));
    counter = 0;
    drain();

    // extreme divider and scale, plus a zero divider
    set_config(20'hFFFFF, 24'hFFFFFF);
    idle_on = 1;
    send(mk(REQ_START, counter, 0, 0, 0));
    random_phase(75);
    drain();
    set_config(20'd0, 24'd0);
    send(mk(REQ_START, counter, 0, 0, 0));
    random_phase(75);

    // nesting saturation
    send(mk(REQ_TICK, counter, 0, 0, 0));
    for (int i = 0; i < 258; i++) send(mk(REQ_SUSP, counter + 64'(i), 0, 0, 0));
    send(mk(REQ_RESUME, counter + 64'd500, 0, 0, 0));
    send(mk(REQ_START, counter, 0, 0, 0));
    drain();

    // long hold-off on the result side while requests keep coming
    set_config(20'd50000, 24'd32768);
    idle_on = 0;
    hold_off = 1;
    random_phase(100);
    drain();

    set_config(20'd1, 24'd65536);
    idle_on = 1;
    random_phase(60);
    drain();
    set_config(20'($urandom_range(1, 1048575)), 24'($urandom));
    random_phase(60);
    drain();

    $display("sent %0d requests (%0d frame ticks) over %0d register settings",
             n_req, n_tick, n_phase + 1);
    $display("covered clamps, pauses, suspend nesting, stop, unknown codes and a long hold-off");
    if (fail_count == 0) begin
      $display("frame_time_accumulator verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("frame_time_accumulator verification failed");
    end
    $finish;
  end

endmodule
